[src/hof_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_pkg
// shared types and constants of the hampel outlier filter
// ----------------------------------------------------------------------------
package hof_pkg;

    localparam int SampleBits = 16;

    typedef struct packed {
        logic signed [SampleBits-1:0] sample;
        logic                         last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SampleBits-1:0] value;
        logic                         replaced;
        logic                         last_out;
    } out_item_t;

    typedef enum logic [0:0] {
        REG_HALF_WIDTH = 1'b0,
        REG_THRESHOLD  = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_RANK_MED,
        ST_PICK_MED,
        ST_DEV,
        ST_RANK_MAD,
        ST_PICK_MAD,
        ST_MUL,
        ST_DECIDE,
        ST_EMIT,
        ST_FLUSH,
        ST_FLUSH_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic write_sample;
        logic load_window;
        logic rank_step;
        logic rank_clear;
        logic pick_med;
        logic make_dev;
        logic pick_mad;
        logic mul_step;
        logic decide;
        logic emit_raw;
        logic flush_load;
        logic flush_step;
        logic clear_stream;
        logic out_valid;
    } hof_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_centre;
        logic full_window;
        logic rank_done;
        logic flush_any;
        logic flush_final;
        logic last_seen;
    } hof_stat_t;

endpackage

[src/hampel_outlier_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hampel_outlier_filter
// streaming hampel filter: window median and mad, outliers replaced
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | in_data   (sample, last_in)
//  out     | out_valid / out_ready| out_data  (value, replaced, last_out)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  a full-window sample runs two rank passes of the shared comparator row,
//  one candidate per cycle, then one multiply
//  short-window samples skip both rank passes; a flush emits the held samples
//  reset clears the ring pointer and fill count; ring contents stay undefined
//  a stalled output holds the controller; no input is taken meanwhile
// ----------------------------------------------------------------------------
module hampel_outlier_filter
    import hof_pkg::*;
#(
    parameter int MAX_HALF = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data
);

    hof_cmd_t   cmd;
    hof_stat_t  stat;
    logic [3:0]  half_reg;
    logic [15:0] gain_reg;
    logic        cfg_fire;
    logic        in_fire;
    logic signed [SampleBits-1:0] value_w;
    logic        repl_w;
    logic        last_w;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 4'd3;
            gain_reg <= 16'd1139;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_HALF_WIDTH: half_reg <= cfg_data[3:0];
                REG_THRESHOLD:  gain_reg <= cfg_data;
                default:        half_reg <= half_reg;
            endcase
        end
    end

    hof_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    hof_datapath #(
        .MAX_HALF(MAX_HALF)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_sample     (in_data.sample),
        .in_last       (in_data.last_in),
        .cfg_half_we   (cfg_fire && cfg_index == REG_HALF_WIDTH),
        .half_width    (half_reg),
        .threshold_gain(gain_reg),
        .stat          (stat),
        .out_value     (value_w),
        .out_replaced  (repl_w),
        .out_last      (last_w)
    );

    assign out_data  = {value_w, repl_w, last_w};
    assign out_valid = cmd.out_valid;

`ifndef SYNTHESIS
    // no new transfer while a result waits
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while output pending");

    // a replaced result is never a flush result
    a_repl_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.replaced && out_data.last_out))
        else $error("replaced flush output");

    // an input transfer always starts a sample store
    a_write_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> cmd.write_sample)
        else $error("input transfer without store");
`endif

endmodule

[src/hof_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_ctrl
// sequencer for one sample: store, two rank selections, decision, flush
// ----------------------------------------------------------------------------
module hof_ctrl
    import hof_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_ready,
    input  hof_stat_t stat,
    output hof_cmd_t  cmd,
    output logic      in_ready
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.write_sample = 1'b1;
                    state_next       = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (stat.have_centre && stat.full_window)
                begin
                    state_next = ST_LOAD;
                end
                else if (stat.have_centre)
                begin
                    cmd.emit_raw = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_LOAD:
            begin
                cmd.load_window = 1'b1;
                cmd.rank_clear  = 1'b1;
                state_next      = ST_RANK_MED;
            end
            ST_RANK_MED:
            begin
                cmd.rank_step = 1'b1;
                if (stat.rank_done)
                begin
                    state_next = ST_PICK_MED;
                end
            end
            ST_PICK_MED:
            begin
                cmd.pick_med = 1'b1;
                state_next   = ST_DEV;
            end
            ST_DEV:
            begin
                cmd.make_dev   = 1'b1;
                cmd.rank_clear = 1'b1;
                state_next     = ST_RANK_MAD;
            end
            ST_RANK_MAD:
            begin
                cmd.rank_step = 1'b1;
                if (stat.rank_done)
                begin
                    state_next = ST_PICK_MAD;
                end
            end
            ST_PICK_MAD:
            begin
                cmd.pick_mad = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (stat.last_seen)
                begin
                    cmd.flush_load = 1'b1;
                    if (stat.flush_any)
                    begin
                        state_next = ST_FLUSH_OUT;
                    end
                    else
                    begin
                        cmd.clear_stream = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_OUT:
            begin
                cmd.out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.flush_final)
                    begin
                        cmd.clear_stream = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        cmd.flush_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/hof_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_datapath
// sample ring, rank-select unit, mad compare and output register
// ----------------------------------------------------------------------------
module hof_datapath
    import hof_pkg::*;
#(
    parameter int MAX_HALF = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hof_cmd_t               cmd,
    input  logic signed [SampleBits-1:0] in_sample,
    input  logic                   in_last,
    input  logic                   cfg_half_we,
    input  logic [3:0]             half_width,
    input  logic [15:0]            threshold_gain,
    output hof_stat_t              stat,
    output logic signed [SampleBits-1:0] out_value,
    output logic                   out_replaced,
    output logic                   out_last
);

    localparam int Depth = 2 * MAX_HALF + 1;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam int DevW  = SampleBits + 1;
    localparam int ProdW = DevW + 16;

    logic signed [SampleBits-1:0] ring_reg [Depth];
    logic [PtrW-1:0]  wptr_reg;
    logic [CntW-1:0]  count_reg;
    logic             last_reg;
    logic signed [DevW-1:0] work_reg [Depth];
    logic [CntW-1:0]  rank_idx_reg;
    logic [CntW-1:0]  less_reg [Depth];
    logic [CntW-1:0]  eq_reg   [Depth];
    logic signed [SampleBits-1:0] med_reg;
    logic signed [SampleBits-1:0] centre_reg;
    logic [DevW-1:0]  mad_reg;
    logic [ProdW-1:0] lhs_reg;
    logic [ProdW-1:0] rhs_reg;
    logic [CntW-1:0]  flush_p_reg;
    logic signed [SampleBits-1:0] out_value_reg;
    logic             out_repl_reg;
    logic             out_last_reg;

    logic [CntW-1:0]  k_eff;
    logic [CntW-1:0]  w_eff;
    logic [CntW-1:0]  flush_n;
    logic signed [DevW-1:0] pick_val;
    logic signed [DevW-1:0] cand;

    // effective half width, clamped to the supported range
    always_comb
    begin
        if (half_width == 4'd0)
        begin
            k_eff = CntW'(1);
        end
        else if (32'(half_width) > MAX_HALF)
        begin
            k_eff = CntW'(MAX_HALF);
        end
        else
        begin
            k_eff = CntW'(half_width);
        end
        w_eff = CntW'({k_eff, 1'b1});
    end

    // ring index of the sample d steps back from the newest
    function automatic logic [PtrW-1:0] back_idx(input logic [PtrW-1:0] wp,
                                                 input logic [CntW-1:0] d);
        logic [PtrW:0] s;
        s = {1'b0, wp} + (PtrW+1)'(Depth - 1) - (PtrW+1)'(d);
        if (s >= (PtrW+1)'(Depth))
        begin
            s = s - (PtrW+1)'(Depth);
        end
        return s[PtrW-1:0];
    endfunction

    assign flush_n = (count_reg < k_eff) ? count_reg : k_eff;

    // status to controller
    always_comb
    begin
        stat.have_centre = count_reg > k_eff;
        stat.full_window = count_reg == w_eff;
        stat.rank_done   = rank_idx_reg == w_eff - CntW'(1);
        stat.flush_any   = flush_n != '0;
        stat.flush_final = flush_p_reg == '0;
        stat.last_seen   = last_reg;
    end

    // sample ring and stream counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            count_reg <= '0;
            last_reg  <= 1'b0;
        end
        else if (cfg_half_we || cmd.clear_stream)
        begin
            wptr_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.write_sample)
        begin
            wptr_reg <= (wptr_reg == PtrW'(Depth - 1)) ? '0 : wptr_reg + PtrW'(1);
            if (count_reg < w_eff)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else
            begin
                count_reg <= w_eff;
            end
            last_reg <= in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_sample)
        begin
            ring_reg[wptr_reg] <= in_sample;
        end
    end

    // candidate for the current rank step
    assign cand = work_reg[rank_idx_reg[PtrW-1:0]];

    // window copy, deviations, rank counting one candidate per cycle, picks, products
    always_ff @(posedge clk)
    begin
        if (cmd.load_window)
        begin
            for (int d = 0; d < Depth; d++)
            begin
                work_reg[d] <= DevW'(ring_reg[back_idx(wptr_reg, CntW'(d))]);
            end
            centre_reg <= ring_reg[back_idx(wptr_reg, k_eff)];
        end
        else if (cmd.make_dev)
        begin
            for (int d = 0; d < Depth; d++)
            begin
                if (work_reg[d] < DevW'(med_reg))
                begin
                    work_reg[d] <= DevW'(med_reg) - work_reg[d];
                end
                else
                begin
                    work_reg[d] <= work_reg[d] - DevW'(med_reg);
                end
            end
        end
        if (cmd.rank_clear)
        begin
            rank_idx_reg <= '0;
            for (int d = 0; d < Depth; d++)
            begin
                less_reg[d] <= '0;
                eq_reg[d]   <= '0;
            end
        end
        else if (cmd.rank_step)
        begin
            // every window element compares against the shared candidate
            for (int d = 0; d < Depth; d++)
            begin
                if (CntW'(d) < w_eff)
                begin
                    if (cand < work_reg[d])
                    begin
                        less_reg[d] <= less_reg[d] + CntW'(1);
                    end
                    else if (cand == work_reg[d])
                    begin
                        eq_reg[d] <= eq_reg[d] + CntW'(1);
                    end
                end
            end
            if (rank_idx_reg != w_eff - CntW'(1))
            begin
                rank_idx_reg <= rank_idx_reg + CntW'(1);
            end
        end
        if (cmd.pick_med)
        begin
            med_reg <= pick_val[SampleBits-1:0];
        end
        if (cmd.pick_mad)
        begin
            mad_reg <= pick_val;
        end
        if (cmd.mul_step)
        begin
            lhs_reg <= ProdW'(work_reg[k_eff[PtrW-1:0]]) << 8;
            rhs_reg <= ProdW'(mad_reg) * ProdW'(threshold_gain);
        end
    end

    // element whose rank window covers position k
    always_comb
    begin
        pick_val = work_reg[0];
        for (int d = 0; d < Depth; d++)
        begin
            if (CntW'(d) < w_eff && less_reg[d] <= k_eff &&
                k_eff < less_reg[d] + eq_reg[d])
            begin
                pick_val = work_reg[d];
            end
        end
    end

    // flush pointer
    always_ff @(posedge clk)
    begin
        if (cmd.flush_load)
        begin
            flush_p_reg <= flush_n - CntW'(1);
        end
        else if (cmd.flush_step)
        begin
            flush_p_reg <= flush_p_reg - CntW'(1);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_raw)
        begin
            out_value_reg <= ring_reg[back_idx(wptr_reg, k_eff)];
            out_repl_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.decide)
        begin
            if (lhs_reg > rhs_reg)
            begin
                out_value_reg <= med_reg;
                out_repl_reg  <= 1'b1;
            end
            else
            begin
                out_value_reg <= centre_reg;
                out_repl_reg  <= 1'b0;
            end
            out_last_reg <= 1'b0;
        end
        else if (cmd.flush_load)
        begin
            out_value_reg <= ring_reg[back_idx(wptr_reg, flush_n - CntW'(1))];
            out_repl_reg  <= 1'b0;
            out_last_reg  <= flush_n == CntW'(1);
        end
        else if (cmd.flush_step)
        begin
            out_value_reg <= ring_reg[back_idx(wptr_reg, flush_p_reg - CntW'(1))];
            out_repl_reg  <= 1'b0;
            out_last_reg  <= flush_p_reg == CntW'(1);
        end
    end

    assign out_value    = out_value_reg;
    assign out_replaced = out_repl_reg;
    assign out_last     = out_last_reg;

endmodule

[verif/hampel_outlier_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hampel_outlier_filter_test
// self-checking regression of the streaming hampel filter: directed and random
// sample streams under random idling, each result checked against a local
// window median / mad predictor
// ----------------------------------------------------------------------------
module hampel_outlier_filter_test;
    import hof_pkg::*;

    localparam int RingDepth = 17;
    localparam int MaxHalf   = 8;
    localparam int CycleLimit = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // predictor state
    logic signed [15:0] ring [RingDepth];
    int unsigned        wr_ptr;
    int unsigned        fill_count;
    logic [3:0]         half_reg;
    logic [15:0]        gain_reg;

    out_item_t expected_q[$];
    int        error_count;
    int        result_count;
    int        replaced_count;
    int        sample_count;
    int        cycle_count;

    hampel_outlier_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("%0t: timeout with %0d results pending", $time, expected_q.size());
            $display("hampel_outlier_filter regression: fail");
            $finish;
        end
    end

    function automatic int unsigned window_half();
        int unsigned k;
        k = half_reg;
        if (k < 1) k = 1;
        if (k > MaxHalf) k = MaxHalf;
        return k;
    endfunction

    function automatic logic signed [15:0] aged(int unsigned d);
        return ring[(wr_ptr + RingDepth - 1 - d) % RingDepth];
    endfunction

    function automatic out_item_t make_result(logic signed [15:0] v, logic repl, logic fin);
        out_item_t r;
        r.value    = v;
        r.replaced = repl;
        r.last_out = fin;
        return r;
    endfunction

    // lower middle of w values by rank counting
    function automatic longint middle_of(longint vals[RingDepth], int unsigned w);
        int unsigned i;
        int unsigned j;
        int unsigned below;
        int unsigned equal;
        longint      pick;
        pick = 0;
        for (i = 0; i < w; i++)
        begin
            below = 0;
            equal = 0;
            for (j = 0; j < w; j++)
            begin
                if (vals[j] < vals[i]) below++;
                else if (vals[j] == vals[i]) equal++;
            end
            if (below <= w / 2 && below + equal > w / 2) pick = vals[i];
        end
        return pick;
    endfunction

    // median / mad decision for one accepted sample, plus flush
    task automatic predict_filter(in_item_t item);
        int unsigned        k;
        int unsigned        w;
        int unsigned        d;
        longint             vals[RingDepth];
        longint             med;
        longint             mad;
        longint             dev;
        logic signed [15:0] centre;
        int unsigned        pend;
        k = window_half();
        w = 2 * k + 1;
        ring[wr_ptr] = item.sample;
        wr_ptr = (wr_ptr + 1) % RingDepth;
        if (fill_count < w) fill_count++;
        if (fill_count > k)
        begin
            centre = aged(k);
            if (fill_count == w)
            begin
                for (d = 0; d < w; d++) vals[d] = aged(d);
                med = middle_of(vals, w);
                for (d = 0; d < w; d++)
                begin
                    dev = longint'(aged(d)) - med;
                    vals[d] = dev < 0 ? -dev : dev;
                end
                mad = middle_of(vals, w);
                dev = longint'(centre) - med;
                if (dev < 0) dev = -dev;
                if (dev * 256 > mad * longint'(gain_reg))
                    expected_q.push_back(make_result(16'(med), 1'b1, 1'b0));
                else
                    expected_q.push_back(make_result(centre, 1'b0, 1'b0));
            end
            else
            begin
                expected_q.push_back(make_result(centre, 1'b0, 1'b0));
            end
        end
        if (item.last_in)
        begin
            pend = fill_count < k ? fill_count : k;
            while (pend > 0)
            begin
                pend--;
                expected_q.push_back(make_result(aged(pend), 1'b0, pend == 0));
            end
            wr_ptr = 0;
            fill_count = 0;
        end
    endtask

    // result checker with random back-pressure
    initial
    begin
        int         stall;
        out_item_t  exp_item;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            result_count++;
            if (expected_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result value=%0d replaced=%0b last=%0b",
                         $time, out_data.value, out_data.replaced, out_data.last_out);
            end
            else
            begin
                exp_item = expected_q.pop_front();
                if (out_data.replaced) replaced_count++;
                if (out_data.value !== exp_item.value)
                begin
                    error_count++;
                    $display("%0t: value expected %0d actual %0d", $time,
                             exp_item.value, out_data.value);
                end
                if (out_data.replaced !== exp_item.replaced)
                begin
                    error_count++;
                    $display("%0t: replaced expected %0b actual %0b", $time,
                             exp_item.replaced, out_data.replaced);
                end
                if (out_data.last_out !== exp_item.last_out)
                begin
                    error_count++;
                    $display("%0t: last_out expected %0b actual %0b", $time,
                             exp_item.last_out, out_data.last_out);
                end
            end
        end
    end

    // one sample transfer with a random gap ahead of it; valid stays high
    // after the transfer until the next gap or pause lowers it
    task automatic send_sample(logic signed [15:0] s, logic fin, bit no_gap = 0);
        in_item_t item;
        int       gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.sample  = s;
        item.last_in = fin;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_filter(item);
        sample_count++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_HALF_WIDTH)
        begin
            half_reg   = val[3:0];
            wr_ptr     = 0;
            fill_count = 0;
        end
        else
        begin
            gain_reg = val;
        end
    endtask

    function automatic logic signed [15:0] noisy_sample(int spread);
        logic signed [15:0] s;
        case ($urandom_range(0, 9))
            0: s = 16'sh7fff;
            1: s = 16'sh8000;
            2: s = 16'($urandom);
            default: s = 16'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
        return s;
    endfunction

    // stream of mostly smooth data with spikes
    task automatic send_stream(int len, int spread);
        int i;
        for (i = 0; i < len; i++)
            send_sample(noisy_sample(spread), i == len - 1);
    endtask

    // extremes, spikes, flat window, short stream
    task automatic test_directed();
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shffff, 1'b1);
        // short stream: fewer than k samples, flush only
        send_sample(16'sh0123, 1'b0);
        send_sample(16'sh5555, 1'b1);
        // single-sample stream
        send_sample(16'shaaaa, 1'b1);
    endtask

    // half widths including out-of-range codes, gain extremes
    task automatic test_settings();
        int hw;
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_HALF_WIDTH, 16'd1);
        send_stream(8, 20);
        write_reg(REG_THRESHOLD, 16'hffff);
        write_reg(REG_HALF_WIDTH, 16'd8);
        send_stream(20, 20);
        write_reg(REG_HALF_WIDTH, 16'd0);
        send_stream(6, 20);
        write_reg(REG_HALF_WIDTH, 16'd15);
        write_reg(REG_THRESHOLD, 16'd384);
        send_stream(20, 50);
        // dropped stream on half width write
        send_sample(16'sh0042, 1'b0);
        send_sample(16'sh0043, 1'b0);
        hw = $urandom_range(2, 7);
        write_reg(REG_HALF_WIDTH, 16'(hw));
        send_stream(12, 10);
    endtask

    // random streams under random settings; at least one full-drain pause before each
    task automatic test_random();
        int n;
        n = 0;
        while (n < 120)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(REG_HALF_WIDTH, 16'($urandom_range(0, 15)));
                write_reg(REG_THRESHOLD, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                       : 16'($urandom_range(0, 2000)));
            end
            else
            begin
                wait_drained();
            end
            begin
                int len;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 30);
                send_stream(len, $urandom_range(0, 1) ? 4 : 3000);
                n += len;
            end
        end
    endtask

    initial
    begin
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        error_count = 0;
        result_count = 0;
        replaced_count = 0;
        sample_count = 0;
        cycle_count = 0;
        wr_ptr      = 0;
        fill_count  = 0;
        half_reg    = 4'd3;
        gain_reg    = 16'd1139;
        for (int i = 0; i < RingDepth; i++) ring[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_random();
        wait_drained();
        $display("covered %0d samples, %0d results, %0d replaced by the median",
                 sample_count, result_count, replaced_count);
        if (error_count == 0 && expected_q.size() == 0)
            $display("hampel_outlier_filter regression: pass");
        else
            $display("hampel_outlier_filter regression: fail");
        $finish;
    end

endmodule
